>>> rtl/i2c_master_byte_engine_core_macros.svh
// Assertion macros shared by the engine modules.
// Every macro samples on aclk and is switched off while aresetn is low.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define I2CBE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("engine check failed");

// The consequent holds in the same cycle as the antecedent.
`define I2CBE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("engine check failed");

// The consequent holds in the cycle after the antecedent.
`define I2CBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("engine check failed");

`else

`define I2CBE_ASSERT_ALWAYS(label, cond)
`define I2CBE_ASSERT_SAME(label, ante, cons)
`define I2CBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/i2cbe_pkg.sv
package i2cbe_pkg;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Queue between the front and the sequencer.
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Bus timing and byte framing.
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam int          BYTE_MSB          = 7;

    // Command codes as carried on the input stream.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Bus sequencer phases.
    typedef enum logic [18:0] {
        PH_IDLE       = 19'h00001,
        PH_ST1        = 19'h00002,
        PH_ST2        = 19'h00004,
        PH_ST3        = 19'h00008,
        PH_ST4        = 19'h00010,
        PH_SP1        = 19'h00020,
        PH_SP2        = 19'h00040,
        PH_SP3        = 19'h00080,
        PH_TX_LOW     = 19'h00100,
        PH_TX_HIGH    = 19'h00200,
        PH_TX_ACKLOW  = 19'h00400,
        PH_TX_ACKHIGH = 19'h00800,
        PH_RX_PRE     = 19'h01000,
        PH_RX_WAIT    = 19'h02000,
        PH_RX_HIGH    = 19'h04000,
        PH_RX_LOW     = 19'h08000,
        PH_RX_ACKSET  = 19'h10000,
        PH_RX_ACKHIGH = 19'h20000,
        PH_RX_ACKEND  = 19'h40000
    } phase_t;

    // One classified tick: the command is decoded into one-hot flags that
    // are already qualified by command_valid.
    typedef struct packed {
        logic       do_start;
        logic       do_stop;
        logic       do_write;
        logic       do_read;
        logic [7:0] write_data;
        logic       send_ack;
        logic       scl_sense;
        logic       sda_sense;
    } item_t;

endpackage

>>> rtl/i2c_master_byte_engine_core.sv
// Channel   Ports                       Transaction carries
// -------   -------------------------   ---------------------------------------------
// input     s_tvalid s_tready s_tdata   one bus tick: command fields and line levels
//           s_tuser                     command_valid, command
// output    m_tvalid m_tready m_tdata   drives, ready, done, read byte, ACK for a tick
// config    cfg_wr_en cfg_wr_data       half_period_ticks
//
// Every input transaction yields exactly one output transaction.
// Sustained rate is one transaction per cycle while the output is not stalled; a tick
// passes the front stage, the four-entry tick queue and the sequencer's output register.
// Unless the output stalls, the sequencer takes one tick per cycle in one state machine step.
// Reset is synchronous and active low; no clearing pass is needed after it.
// Either side may stall on its own: the queue absorbs ticks while the output waits.
module i2c_master_byte_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: write_data[7:0], send_ack, scl_sense, sda_sense, zero fill.
    input  logic [i2cbe_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: command_valid, command[1:0].
    input  logic [i2cbe_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: scl_pull_low, sda_pull_low, ready_res, done_res,
    // read_data[7:0], ack_sampled, zero fill.
    output logic [i2cbe_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cbe_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  bk_valid;
    logic  bk_ready;
    item_t bk_item;

    // Front: accept and classify ticks.
    i2cbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fr_valid),
        .q_ready  (fr_ready),
        .q_item   (fr_item)
    );

    // Tick queue between the two halves.
    i2cbe_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_item  (bk_item)
    );

    // Back: bus sequencer and result register.
    i2cbe_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (bk_valid),
        .q_ready     (bk_ready),
        .q_item      (bk_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> rtl/i2cbe_front.sv
module i2cbe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: write_data[7:0], send_ack, scl_sense, sda_sense, zero fill.
    input  logic [i2cbe_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: command_valid, command[1:0].
    input  logic [i2cbe_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            q_valid,
    input  logic                            q_ready,
    output i2cbe_pkg::item_t                q_item
);
    import i2cbe_pkg::*;

    logic  stage_valid_reg;
    item_t stage_item_reg;
    item_t item_class;
    cmd_t  cmd_code;
    logic  cmd_valid;
    logic  take;

    // Decode the command into one-hot flags gated by the valid flag.
    always_comb begin
        cmd_valid = s_tuser[0];
        cmd_code  = cmd_t'(s_tuser[2:1]);
        item_class            = '0;
        item_class.write_data = s_tdata[7:0];
        item_class.send_ack   = s_tdata[8];
        item_class.scl_sense  = s_tdata[9];
        item_class.sda_sense  = s_tdata[10];
        unique case (cmd_code)
            CMD_START: item_class.do_start = cmd_valid;
            CMD_STOP:  item_class.do_stop  = cmd_valid;
            CMD_WRITE: item_class.do_write = cmd_valid;
            CMD_READ:  item_class.do_read  = cmd_valid;
            default:   item_class.do_read  = 1'b0;
        endcase
    end

    // The stage accepts a new transaction whenever it is empty or drains now.
    assign s_tready = !stage_valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (take) begin
            stage_valid_reg <= 1'b1;
        end else if (q_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            stage_item_reg <= item_class;
        end
    end

    assign q_valid = stage_valid_reg;
    assign q_item  = stage_item_reg;

endmodule

>>> rtl/i2cbe_fifo.sv
`include "i2c_master_byte_engine_core_macros.svh"

module i2cbe_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  i2cbe_pkg::item_t wr_item,
    output logic             rd_valid,
    input  logic             rd_ready,
    output i2cbe_pkg::item_t rd_item
);
    import i2cbe_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != FIFO_DEPTH[FIFO_AW:0]);
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    // Occupancy moves by one for a lone push or a lone pop.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `I2CBE_ASSERT_ALWAYS(a_fifo_bound, count_reg <= FIFO_DEPTH[FIFO_AW:0])
    `I2CBE_ASSERT_NEXT(a_fifo_grow, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `I2CBE_ASSERT_NEXT(a_fifo_ptr_gap, pop && !push,
                       (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])

endmodule

>>> rtl/i2cbe_seq.sv
`include "i2c_master_byte_engine_core_macros.svh"

module i2cbe_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  i2cbe_pkg::item_t                q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: scl_pull_low, sda_pull_low, ready_res, done_res,
    // read_data[7:0], ack_sampled, zero fill.
    output logic [i2cbe_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cbe_pkg::*;

    logic [15:0]           half_period_reg;
    logic [15:0]           delay_ticks;
    phase_t                phase_reg,   phase_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [3:0]            bit_cnt_inc;
    logic [7:0]            shift_reg,   shift_next;
    logic [15:0]           wait_reg,    wait_next;
    logic                  ack_choice_reg, ack_choice_next;
    logic [7:0]            rx_byte_reg, rx_byte_next;
    logic                  ack_res_reg, ack_res_next;
    logic                  scl_drv_reg, scl_drv_next;
    logic                  sda_drv_reg, sda_drv_next;
    logic                  done_next;
    logic                  step;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    // Delay register; a zero setting behaves as one tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    assign delay_ticks = (half_period_reg == '0) ? 16'd1 : half_period_reg;
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;

    // One tick is consumed whenever the output register is free or drains.
    assign q_ready = !out_valid_reg || m_tready;
    assign step    = q_valid && q_ready;

    // Next state for one bus tick.
    always_comb begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        ack_choice_next = ack_choice_reg;
        rx_byte_next    = rx_byte_reg;
        ack_res_next    = ack_res_reg;
        scl_drv_next    = scl_drv_reg;
        sda_drv_next    = sda_drv_reg;
        done_next       = 1'b0;

        if (phase_reg == PH_IDLE) begin
            // Idle: latch a new command and schedule its first action.
            if (q_item.do_start) begin
                sda_drv_next = 1'b0;
                wait_next    = delay_ticks;
                phase_next   = PH_ST1;
            end else if (q_item.do_stop) begin
                sda_drv_next = 1'b1;
                wait_next    = delay_ticks;
                phase_next   = PH_SP1;
            end else if (q_item.do_write) begin
                shift_next   = q_item.write_data;
                bit_cnt_next = '0;
                sda_drv_next = !q_item.write_data[BYTE_MSB];
                wait_next    = delay_ticks;
                phase_next   = PH_TX_LOW;
            end else if (q_item.do_read) begin
                ack_choice_next = q_item.send_ack;
                shift_next      = '0;
                bit_cnt_next    = '0;
                sda_drv_next    = 1'b0;
                wait_next       = delay_ticks;
                phase_next      = PH_RX_PRE;
            end
        end else if (phase_reg == PH_RX_WAIT) begin
            // Clock stretching: hold until the slave lets SCL rise.
            scl_drv_next = 1'b0;
            if (q_item.scl_sense) begin
                wait_next  = delay_ticks;
                phase_next = PH_RX_HIGH;
            end
        end else if (wait_reg > 16'd1) begin
            wait_next = wait_reg - 16'd1;
        end else begin
            // Delay has run out: take the scheduled action.
            unique case (phase_reg)
                PH_ST1: begin
                    scl_drv_next = 1'b0;
                    wait_next    = delay_ticks;
                    phase_next   = PH_ST2;
                end
                PH_ST2: begin
                    sda_drv_next = 1'b1;
                    wait_next    = delay_ticks;
                    phase_next   = PH_ST3;
                end
                PH_ST3: begin
                    scl_drv_next = 1'b1;
                    wait_next    = delay_ticks;
                    phase_next   = PH_ST4;
                end
                PH_SP1: begin
                    scl_drv_next = 1'b0;
                    wait_next    = delay_ticks;
                    phase_next   = PH_SP2;
                end
                PH_SP2: begin
                    sda_drv_next = 1'b0;
                    wait_next    = delay_ticks;
                    phase_next   = PH_SP3;
                end
                PH_ST4, PH_SP3: begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_TX_LOW: begin
                    scl_drv_next = 1'b0;
                    shift_next   = {shift_reg[BYTE_MSB-1:0], 1'b0};
                    wait_next    = delay_ticks;
                    phase_next   = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    scl_drv_next = 1'b1;
                    bit_cnt_next = bit_cnt_inc;
                    wait_next    = delay_ticks;
                    if (bit_cnt_inc < BITS_PER_BYTE) begin
                        sda_drv_next = !shift_reg[BYTE_MSB];
                        phase_next   = PH_TX_LOW;
                    end else begin
                        sda_drv_next = 1'b0;
                        phase_next   = PH_TX_ACKLOW;
                    end
                end
                PH_TX_ACKLOW: begin
                    scl_drv_next = 1'b0;
                    wait_next    = delay_ticks;
                    phase_next   = PH_TX_ACKHIGH;
                end
                PH_TX_ACKHIGH: begin
                    ack_res_next = q_item.sda_sense;
                    scl_drv_next = 1'b1;
                    phase_next   = PH_IDLE;
                    done_next    = 1'b1;
                end
                PH_RX_PRE: begin
                    scl_drv_next = 1'b0;
                    phase_next   = PH_RX_WAIT;
                end
                PH_RX_HIGH: begin
                    shift_next   = {shift_reg[BYTE_MSB-1:0], q_item.sda_sense};
                    scl_drv_next = 1'b1;
                    wait_next    = delay_ticks;
                    phase_next   = PH_RX_LOW;
                end
                PH_RX_LOW: begin
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc < BITS_PER_BYTE) begin
                        scl_drv_next = 1'b0;
                        phase_next   = PH_RX_WAIT;
                    end else begin
                        sda_drv_next = ack_choice_reg;
                        wait_next    = delay_ticks;
                        phase_next   = PH_RX_ACKSET;
                    end
                end
                PH_RX_ACKSET: begin
                    scl_drv_next = 1'b0;
                    wait_next    = delay_ticks;
                    phase_next   = PH_RX_ACKHIGH;
                end
                PH_RX_ACKHIGH: begin
                    scl_drv_next = 1'b1;
                    wait_next    = delay_ticks;
                    phase_next   = PH_RX_ACKEND;
                end
                PH_RX_ACKEND: begin
                    sda_drv_next = 1'b0;
                    rx_byte_next = shift_reg;
                    phase_next   = PH_IDLE;
                    done_next    = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Sequencer state advances once per consumed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            wait_reg       <= '0;
            ack_choice_reg <= 1'b0;
            rx_byte_reg    <= '0;
            ack_res_reg    <= 1'b0;
            scl_drv_reg    <= 1'b0;
            sda_drv_reg    <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            wait_reg       <= wait_next;
            ack_choice_reg <= ack_choice_next;
            rx_byte_reg    <= rx_byte_next;
            ack_res_reg    <= ack_res_next;
            scl_drv_reg    <= scl_drv_next;
            sda_drv_reg    <= sda_drv_next;
        end
    end

    // Output register holds the result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {3'b000, ack_res_next, rx_byte_next, done_next,
                             (phase_next == PH_IDLE), sda_drv_next, scl_drv_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `I2CBE_ASSERT_ALWAYS(a_bit_cnt_range, bit_cnt_reg <= BITS_PER_BYTE)
    `I2CBE_ASSERT_SAME(a_timed_phase_armed,
                       phase_reg != PH_IDLE && phase_reg != PH_RX_WAIT, wait_reg != '0)
    `I2CBE_ASSERT_NEXT(a_wait_countdown,
                       step && phase_reg != PH_IDLE && phase_reg != PH_RX_WAIT
                       && wait_reg > 16'd1,
                       wait_reg == $past(wait_reg) - 16'd1 && phase_reg == $past(phase_reg))
    `I2CBE_ASSERT_NEXT(a_done_is_idle, step && done_next,
                       phase_reg == PH_IDLE && out_data_reg[2] && out_data_reg[3])

endmodule

>>> dv/i2c_master_byte_engine_core_tb.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_core_tb;
    import i2cbe_pkg::*;

    // One bus tick as carried on the input stream.
    typedef struct packed {
        logic       valid;
        cmd_t       cmd;
        logic [7:0] wdata;
        logic       sack;
        logic       scl;
        logic       sda;
    } bus_tick_t;

    // One output transaction, laid out exactly as m_tdata from bit 0 up.
    typedef struct packed {
        logic [2:0] zero_fill;
        logic       ack_sampled;
        logic [7:0] read_data;
        logic       done_res;
        logic       ready_res;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } bus_out_t;

    // One row of the directed plan: either a register write or a command tick.
    typedef struct packed {
        logic      set_cfg;
        logic [15:0] cfg_value;
        bus_tick_t tick;
        logic      typed;
        bus_out_t  want;
    } step_row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE
    } sink_mode_t;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 6;
    localparam int TICKS_PER_PHASE = 90;

    localparam bus_out_t NO_WORD = '0;
    localparam bus_out_t RESET_WORD = '{zero_fill: 3'd0, ack_sampled: 1'b0, read_data: 8'h00,
        done_res: 1'b0, ready_res: 1'b1, sda_pull_low: 1'b0, scl_pull_low: 1'b0};
    localparam bus_out_t STOP_ACCEPT_WORD = '{zero_fill: 3'd0, ack_sampled: 1'b0,
        read_data: 8'h00, done_res: 1'b0, ready_res: 1'b0, sda_pull_low: 1'b1,
        scl_pull_low: 1'b0};

    localparam int PLAN_LEN = 16;
    localparam step_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // Outputs straight after reset.
        '{1'b0, 16'd0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, RESET_WORD},
        // A zero delay register behaves as a one-tick delay.
        '{1'b1, 16'h0000, '0, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, STOP_ACCEPT_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
        // Reads with the clock free, then with the slave stretching it.
        '{1'b0, 16'd0, '{1'b1, CMD_READ, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_READ, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_READ, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, NO_WORD},
        // A longer delay, with one stop run all the way through.
        '{1'b1, 16'd20, '0, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{1'b1, 16'd3, '0, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b1, CMD_WRITE, 8'h5A, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
        '{1'b0, 16'd0, '{1'b0, CMD_READ, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WORD}
    };

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted engine state and the delay register shadow.
    logic [15:0] bus_delay_ticks;
    phase_t      seq_phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [15:0] delay_left;
    logic        ack_choice;
    logic [7:0]  rx_byte;
    logic        ack_bit;
    logic        scl_drv;
    logic        sda_drv;

    bus_out_t    pending_outputs [$];
    int          error_count   = 0;
    int          burst_left    = 0;
    int          scl_low_left  = 0;
    logic        hold_request  = 1'b0;
    logic        full_rate;

    // Very long delays run with neither side idling.
    assign full_rate = (bus_delay_ticks > 16'd1000);

    i2c_master_byte_engine_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #5000000;
        $display("i2c_master_byte_engine_core_tb: errors");
        $finish;
    end

    function automatic void reset_engine();
        bus_delay_ticks = HALF_PERIOD_RESET;
        seq_phase       = PH_IDLE;
        bit_count       = '0;
        shift_byte      = '0;
        delay_left      = '0;
        ack_choice      = 1'b0;
        rx_byte         = '0;
        ack_bit         = 1'b0;
        scl_drv         = 1'b0;
        sda_drv         = 1'b0;
    endfunction

    // Loads the bus delay and moves on to the given phase.
    function automatic void arm_delay(input phase_t nxt);
        delay_left = (bus_delay_ticks == 16'd0) ? 16'd1 : bus_delay_ticks;
        seq_phase  = nxt;
    endfunction

    // Action at the end of a phase's delay; returns 1 when the command completes.
    function automatic logic finish_delay(input logic sda_in);
        logic done;
        done = 1'b0;
        case (seq_phase)
            PH_ST1: begin
                scl_drv = 1'b0;
                arm_delay(PH_ST2);
            end
            PH_ST2: begin
                sda_drv = 1'b1;
                arm_delay(PH_ST3);
            end
            PH_ST3: begin
                scl_drv = 1'b1;
                arm_delay(PH_ST4);
            end
            PH_SP1: begin
                scl_drv = 1'b0;
                arm_delay(PH_SP2);
            end
            PH_SP2: begin
                sda_drv = 1'b0;
                arm_delay(PH_SP3);
            end
            PH_TX_LOW: begin
                scl_drv    = 1'b0;
                shift_byte = shift_byte << 1;
                arm_delay(PH_TX_HIGH);
            end
            PH_TX_HIGH: begin
                scl_drv   = 1'b1;
                bit_count = bit_count + 4'd1;
                if (bit_count < BITS_PER_BYTE) begin
                    sda_drv = ~shift_byte[BYTE_MSB];
                    arm_delay(PH_TX_LOW);
                end else begin
                    sda_drv = 1'b0;
                    arm_delay(PH_TX_ACKLOW);
                end
            end
            PH_TX_ACKLOW: begin
                scl_drv = 1'b0;
                arm_delay(PH_TX_ACKHIGH);
            end
            PH_TX_ACKHIGH: begin
                ack_bit   = sda_in;
                scl_drv   = 1'b1;
                seq_phase = PH_IDLE;
                done      = 1'b1;
            end
            PH_RX_PRE: begin
                scl_drv   = 1'b0;
                seq_phase = PH_RX_WAIT;
            end
            PH_RX_HIGH: begin
                shift_byte = {shift_byte[BYTE_MSB-1:0], sda_in};
                scl_drv    = 1'b1;
                arm_delay(PH_RX_LOW);
            end
            PH_RX_LOW: begin
                bit_count = bit_count + 4'd1;
                if (bit_count < BITS_PER_BYTE) begin
                    scl_drv   = 1'b0;
                    seq_phase = PH_RX_WAIT;
                end else begin
                    sda_drv = ack_choice;
                    arm_delay(PH_RX_ACKSET);
                end
            end
            PH_RX_ACKSET: begin
                scl_drv = 1'b0;
                arm_delay(PH_RX_ACKHIGH);
            end
            PH_RX_ACKHIGH: begin
                scl_drv = 1'b1;
                arm_delay(PH_RX_ACKEND);
            end
            PH_RX_ACKEND: begin
                sda_drv   = 1'b0;
                rx_byte   = shift_byte;
                seq_phase = PH_IDLE;
                done      = 1'b1;
            end
            PH_ST4, PH_SP3: begin
                seq_phase = PH_IDLE;
                done      = 1'b1;
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
        return done;
    endfunction

    // Advances the predicted engine by one tick and forms that tick's output.
    function automatic void step_engine(input bus_tick_t t, output bus_out_t word);
        logic done;
        done = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (t.valid) begin
                case (t.cmd)
                    CMD_START: begin
                        sda_drv = 1'b0;
                        arm_delay(PH_ST1);
                    end
                    CMD_STOP: begin
                        sda_drv = 1'b1;
                        arm_delay(PH_SP1);
                    end
                    CMD_WRITE: begin
                        shift_byte = t.wdata;
                        bit_count  = '0;
                        sda_drv    = ~t.wdata[BYTE_MSB];
                        arm_delay(PH_TX_LOW);
                    end
                    CMD_READ: begin
                        ack_choice = t.sack;
                        shift_byte = '0;
                        bit_count  = '0;
                        sda_drv    = 1'b0;
                        arm_delay(PH_RX_PRE);
                    end
                endcase
            end
        end else if (seq_phase == PH_RX_WAIT) begin
            // Clock stretching: hold until the slave lets SCL go high.
            scl_drv = 1'b0;
            if (t.scl) begin
                arm_delay(PH_RX_HIGH);
            end
        end else if (delay_left > 16'd1) begin
            delay_left = delay_left - 16'd1;
        end else begin
            done = finish_delay(t.sda);
        end
        word              = '0;
        word.scl_pull_low = scl_drv;
        word.sda_pull_low = sda_drv;
        word.ready_res    = (seq_phase == PH_IDLE);
        word.done_res     = done;
        word.read_data    = rx_byte;
        word.ack_sampled  = ack_bit;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] seen,
                               input logic [7:0] wanted);
        if (seen !== wanted) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, seen, wanted));
        end
    endtask

    // Offers one tick in bursts with random gaps; predicts it once accepted.
    task automatic send_tick(input bus_tick_t t, input logic typed, input bus_out_t want);
        bus_out_t predicted;
        if (!full_rate && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, t.sda, t.scl, t.sack, t.wdata};
        s_tuser  <= {t.cmd, t.valid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end
        step_engine(t, predicted);
        pending_outputs.push_back(typed ? want : predicted);
    endtask

    // Stops offering and waits until every predicted transaction has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outputs.size() != 0);
    endtask

    task automatic write_delay_reg(input logic [15:0] value);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bus_delay_ticks = value;
    endtask

    // Random tick: mostly commands when idle, ignored commands when busy,
    // and SCL held low now and then for a stretch.
    function automatic bus_tick_t random_tick();
        bus_tick_t t;
        t.valid = (seq_phase == PH_IDLE) ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 1) == 1);
        t.cmd   = cmd_t'($urandom_range(0, 3));
        t.wdata = 8'($urandom);
        t.sack  = 1'($urandom);
        t.sda   = 1'($urandom);
        if (scl_low_left > 0) begin
            scl_low_left--;
            t.scl = 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            scl_low_left = $urandom_range(4, 40);
            t.scl = 1'b0;
        end else begin
            t.scl = ($urandom_range(0, 3) != 0);
        end
        return t;
    endfunction

    // Receiver pacing: its own stall pattern, plus a long hold-off on request.
    initial begin : sink_pacing
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                m_tready    <= 1'b0;
            end else if (full_rate) begin
                m_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_RANDOM: m_tready <= 1'($urandom);
                    default:     m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each output transaction with the oldest prediction.
    always @(posedge aclk) begin : check_results
        bus_out_t got;
        bus_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_outputs.size() == 0) begin
                report_mismatch("output transaction with nothing predicted");
            end else begin
                want = pending_outputs.pop_front();
                check_field("scl_pull_low", 8'(got.scl_pull_low), 8'(want.scl_pull_low));
                check_field("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
                check_field("ready_res", 8'(got.ready_res), 8'(want.ready_res));
                check_field("done_res", 8'(got.done_res), 8'(want.done_res));
                check_field("read_data", got.read_data, want.read_data);
                check_field("ack_sampled", 8'(got.ack_sampled), 8'(want.ack_sampled));
                check_field("zero_fill", 8'(got.zero_fill), 8'(want.zero_fill));
            end
        end
    end

    initial begin : stimulus
        bus_tick_t   filler;
        int          fill_n;
        logic [15:0] delay_choice;
        reset_engine();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan: each command is followed by ticks until it completes,
        // those ticks repeating the command so that a busy engine must ignore it.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (DIRECTED_PLAN[i].set_cfg) begin
                write_delay_reg(DIRECTED_PLAN[i].cfg_value);
            end else begin
                send_tick(DIRECTED_PLAN[i].tick, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
                fill_n = 0;
                while (seq_phase != PH_IDLE) begin
                    filler     = DIRECTED_PLAN[i].tick;
                    filler.scl = DIRECTED_PLAN[i].tick.scl | (fill_n % 7 == 6);
                    send_tick(filler, 1'b0, NO_WORD);
                    fill_n++;
                end
            end
        end

        // Random phases, each at its own bus delay.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       delay_choice = 16'd1;
                1:       delay_choice = 16'd2;
                2:       delay_choice = 16'd0;
                3:       delay_choice = 16'd3;
                default: delay_choice = 16'($urandom_range(1, 5));
            endcase
            write_delay_reg(delay_choice);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                // Back-pressure long enough to fill the block and stall its input.
                if (ph == 1 && n == 10) begin
                    hold_request = 1'b1;
                end
                if (ph == 3 && n == TICKS_PER_PHASE / 2) begin
                    drain_results();
                end
                send_tick(random_tick(), 1'b0, NO_WORD);
            end
            // Let the last command finish before the delay changes.
            while (seq_phase != PH_IDLE) begin
                send_tick(random_tick(), 1'b0, NO_WORD);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (pending_outputs.size() != 0) begin
            report_mismatch("predicted transactions never arrived");
        end
        if (error_count == 0) begin
            $display("i2c_master_byte_engine_core_tb: clean");
        end else begin
            $display("i2c_master_byte_engine_core_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/i2cbe_pkg.sv
rtl/i2cbe_front.sv
rtl/i2cbe_fifo.sv
rtl/i2cbe_seq.sv
rtl/i2c_master_byte_engine_core.sv
dv/i2c_master_byte_engine_core_tb.sv
